FILE: hdl/sfls_pkg.sv
// shared types and constants for the first/last substring search block
// no dependencies; used by every module under hdl

package sfls_pkg;

	// longest needle the window can hold, and the limit applied to needle_len
	localparam int unsigned MAX_NEEDLE = 16;
	localparam int unsigned NEEDLE_LIM = (MAX_NEEDLE < 16) ? MAX_NEEDLE : 16;
	localparam int unsigned WIN_IDX_W  = (NEEDLE_LIM > 1) ? $clog2(NEEDLE_LIM) : 1;
	localparam int unsigned LEN_W      = 5;

	// text length limit and the byte counter that covers it
	localparam longint unsigned MAX_TEXT = 65535;
	localparam int unsigned SEEN_W = $clog2(MAX_TEXT + 1);
	localparam int unsigned POS_W  = 16;

	// configuration port
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_LO  = 2'd0,
		REG_NEEDLE_HI  = 2'd1,
		REG_NEEDLE_LEN = 2'd2
	} cfg_reg_t;

	// stream payload widths
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_FIELD_W = 1 + POS_W + POS_W + 1;
	localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef logic [7:0] byte_t;
	typedef byte_t [NEEDLE_LIM-1:0] win_t;

	// needle as seen by the compare logic, length already saturated
	typedef struct packed {
		logic [15:0][7:0] bytes;
		logic [LEN_W-1:0] len;
	} needle_cfg_t;

endpackage

FILE: hdl/substring_first_last_search.sv
// Streaming first/last substring search. One text item is accepted every clock cycle;
// each item passes an input register, then the window shift, 16-byte compare and match
// bookkeeping, which load the result register that drives m_tvalid for an end-marked item.
// The input side stalls only when an end-marked item meets a result that has not yet
// been taken. Needle registers are to be written through the cfg port only while no
// text is in flight; the block itself does not enforce this. A write takes effect at the
// next accepted item. Depends on sfls_pkg, sfls_cfg_regs and sfls_match.

module substring_first_last_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [sfls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfls_pkg::CFG_DATA_W-1:0]      cfg_data,
	// text input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [sfls_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] text_byte
	input  logic                                 s_tuser,   // [0] has_byte
	input  logic                                 s_tlast,   // end_of_text
	// result output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] found, [16:1] first_position, [32:17] last_position, [33] too_long, rest zero
	output logic [sfls_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int unsigned SEEN_W = sfls_pkg::SEEN_W;
	localparam int unsigned POS_W  = sfls_pkg::POS_W;

	sfls_pkg::needle_cfg_t needle;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        has_s1;
	logic        eot_s1;

	// search state
	sfls_pkg::win_t      win_q;
	logic [SEEN_W-1:0]   seen_q;
	logic [POS_W-1:0]    first_q;
	logic [POS_W-1:0]    last_q;
	logic                any_q;
	logic                ovf_q;

	// result register
	logic                out_valid_q;
	logic                found_q;
	logic [POS_W-1:0]    first_pos_q;
	logic [POS_W-1:0]    last_pos_q;
	logic                too_long_q;

	logic                stall;
	logic                proc;
	logic                take;
	logic                full;
	sfls_pkg::win_t      win_nxt;
	logic [SEEN_W-1:0]   seen_nxt;
	logic [SEEN_W-1:0]   pos_full;
	logic                eq;
	logic                hit;
	logic [POS_W-1:0]    first_nxt;
	logic [POS_W-1:0]    last_nxt;
	logic                any_nxt;
	logic                ovf_nxt;

	sfls_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.needle    (needle)
	);

	// an end-marked item waits only while the result register is still held
	assign stall    = valid_s1 && eot_s1 && out_valid_q && !m_tready;
	assign s_tready = !stall;
	assign proc     = valid_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			has_s1  <= s_tuser;
			eot_s1  <= s_tlast;
		end
	end

	// byte intake, refused once the text limit is reached
	assign full = (seen_q >= SEEN_W'(sfls_pkg::MAX_TEXT));
	assign take = proc && has_s1 && !full;

	always_comb begin
		win_nxt = win_q;
		if (take) begin
			win_nxt[0] = byte_s1;
			for (int k = 1; k < sfls_pkg::NEEDLE_LIM; k++)
				win_nxt[k] = win_q[k-1];
		end
	end

	assign seen_nxt = take ? seen_q + SEEN_W'(1) : seen_q;
	assign ovf_nxt  = ovf_q || (proc && has_s1 && full);

	sfls_match u_match (
		.win    (win_nxt),
		.needle (needle),
		.eq     (eq)
	);

	// match only once the window holds a full needle
	assign hit = take && (needle.len != '0) && (seen_nxt >= SEEN_W'(needle.len)) && eq;
	assign pos_full = seen_nxt - SEEN_W'(needle.len);

	assign any_nxt   = any_q || hit;
	assign first_nxt = (hit && !any_q) ? POS_W'(pos_full) : first_q;
	assign last_nxt  = hit ? POS_W'(pos_full) : last_q;

	// state update, cleared after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			seen_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			any_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (proc) begin
			if (eot_s1) begin
				win_q   <= '0;
				seen_q  <= '0;
				first_q <= '0;
				last_q  <= '0;
				any_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				win_q   <= win_nxt;
				seen_q  <= seen_nxt;
				first_q <= first_nxt;
				last_q  <= last_nxt;
				any_q   <= any_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// empty needle reports position 0 and the text length
	always_ff @(posedge clk) begin
		if (proc && eot_s1) begin
			too_long_q <= ovf_nxt;
			if (needle.len == '0) begin
				found_q     <= 1'b1;
				first_pos_q <= '0;
				last_pos_q  <= POS_W'(seen_nxt);
			end else if (any_nxt) begin
				found_q     <= 1'b1;
				first_pos_q <= first_nxt;
				last_pos_q  <= last_nxt;
			end else begin
				found_q     <= 1'b0;
				first_pos_q <= '0;
				last_pos_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(sfls_pkg::OUT_TDATA_W - sfls_pkg::OUT_FIELD_W){1'b0}},
		too_long_q, last_pos_q, first_pos_q, found_q};

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && eot_s1 && m_tvalid))
		else $error("input stalled without a pending result");

	// an emitted result leaves the search state clear
	a_clear_after_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && eot_s1) |=> (seen_q == '0 && !any_q && !ovf_q))
		else $error("search state not cleared after result");

	// a recorded match needs at least one byte taken
	a_match_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (seen_q != '0))
		else $error("match recorded with no bytes seen");

	// overflow is flagged only with the counter at its limit
	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (seen_q == SEEN_W'(sfls_pkg::MAX_TEXT)))
		else $error("overflow flag with counter below limit");

	// a new result is loaded only into a free or draining result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> ($stable(first_pos_q) && $stable(last_pos_q)))
		else $error("held result overwritten");

endmodule

FILE: hdl/sfls_cfg_regs.sv
// needle configuration registers with write decode and length saturation
// depends on sfls_pkg

module sfls_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfls_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sfls_pkg::needle_cfg_t              needle
);

	logic [63:0]                  needle_lo_q;
	logic [63:0]                  needle_hi_q;
	logic [sfls_pkg::LEN_W-1:0]   needle_len_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q  <= '0;
			needle_hi_q  <= '0;
			needle_len_q <= '0;
		end else if (cfg_we) begin
			case (sfls_pkg::cfg_reg_t'(cfg_index))
				sfls_pkg::REG_NEEDLE_LO:  needle_lo_q  <= cfg_data[63:0];
				sfls_pkg::REG_NEEDLE_HI:  needle_hi_q  <= cfg_data[63:0];
				sfls_pkg::REG_NEEDLE_LEN: needle_len_q <= cfg_data[sfls_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// byte k of the needle sits at bits 8k+7..8k
	assign needle.bytes = {needle_hi_q, needle_lo_q};

	// lengths above the window depth clamp to it
	assign needle.len = (needle_len_q > sfls_pkg::LEN_W'(sfls_pkg::NEEDLE_LIM))
		? sfls_pkg::LEN_W'(sfls_pkg::NEEDLE_LIM) : needle_len_q;

endmodule

FILE: hdl/sfls_match.sv
// parallel compare of the byte window against the needle
// depends on sfls_pkg; window index 0 holds the newest byte

module sfls_match (
	input  sfls_pkg::win_t         win,
	input  sfls_pkg::needle_cfg_t  needle,
	output logic                   eq
);

	logic [sfls_pkg::LEN_W-1:0] idx;
	logic                       all_eq;

	// needle byte k lines up with window slot len-1-k
	always_comb begin
		all_eq = 1'b1;
		idx    = '0;
		for (int k = 0; k < sfls_pkg::NEEDLE_LIM; k++) begin
			idx = needle.len - sfls_pkg::LEN_W'(1) - sfls_pkg::LEN_W'(k);
			if (sfls_pkg::LEN_W'(k) < needle.len) begin
				if (win[idx[sfls_pkg::WIN_IDX_W-1:0]] != needle.bytes[k])
					all_eq = 1'b0;
			end
		end
	end

	assign eq = all_eq;

endmodule

FILE: test/tb.sv
// self-checking testbench for substring_first_last_search
// depends on sfls_pkg and the block under hdl; needs nothing else to run

module tb;

	// cycles allowed for an item without a result to leave the pipeline
	localparam int unsigned PIPE_FLUSH = 4;
	// index that maps to no register, writes to it must be ignored
	localparam logic [sfls_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// how a text is closed
	localparam int unsigned CLOSE_ON_BYTE = 0;
	localparam int unsigned CLOSE_BARE    = 1;
	localparam int unsigned CLOSE_NONE    = 2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       end_of_text;
	} text_item_t;

	// packed so that found lands in bit 0, as on m_tdata
	typedef struct packed {
		logic                       too_long;
		logic [sfls_pkg::POS_W-1:0] last_pos;
		logic [sfls_pkg::POS_W-1:0] first_pos;
		logic                       found;
	} search_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [sfls_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [sfls_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [sfls_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] text_byte
	logic                             s_tuser = 1'b0; // [0] has_byte
	logic                             s_tlast = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// [0] found, [16:1] first_position, [32:17] last_position, [33] too_long
	logic [sfls_pkg::OUT_TDATA_W-1:0] m_tdata;

	substring_first_last_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// needle registers as the block should hold them
	logic [63:0]                needle_lo = '0;
	logic [63:0]                needle_hi = '0;
	logic [sfls_pkg::LEN_W-1:0] needle_len = '0;

	// search state of the predictor
	sfls_pkg::byte_t            window_q [sfls_pkg::NEEDLE_LIM];
	logic [16:0]                seen_count = '0;
	logic [sfls_pkg::POS_W-1:0] earliest_hit = '0;
	logic [sfls_pkg::POS_W-1:0] latest_hit = '0;
	logic                       any_hit = 1'b0;
	logic                       text_overflow = 1'b0;

	search_result_t   expected_q [$];
	text_item_t       pend_items [$];
	sfls_pkg::byte_t  text_buf [$];

	int  pushed_items = 0;
	int  accepted_items = 0;
	int  result_count = 0;
	int  error_count = 0;
	int  config_count = 0;
	int  random_items = 0;
	bit  idle_on = 1'b1;

	function automatic int unsigned active_len();
		return (needle_len > sfls_pkg::NEEDLE_LIM) ? sfls_pkg::NEEDLE_LIM : needle_len;
	endfunction

	function automatic sfls_pkg::byte_t needle_byte(input int unsigned k);
		if (k < 8)
			return needle_lo[8*k +: 8];
		return needle_hi[8*(k-8) +: 8];
	endfunction

	task automatic clear_search();
		for (int i = 0; i < sfls_pkg::NEEDLE_LIM; i++)
			window_q[i] = 8'h00;
		seen_count    = '0;
		earliest_hit  = '0;
		latest_hit    = '0;
		any_hit       = 1'b0;
		text_overflow = 1'b0;
	endtask

	// advance the search by one accepted item, queue the result it causes
	task automatic search_predict(input text_item_t it);
		int unsigned    len;
		bit             hit;
		logic [16:0]    pos;
		search_result_t res;
		if (it.has_byte) begin
			if (seen_count >= sfls_pkg::MAX_TEXT) begin
				text_overflow = 1'b1;
			end else begin
				for (int i = sfls_pkg::NEEDLE_LIM - 1; i > 0; i--)
					window_q[i] = window_q[i-1];
				window_q[0] = it.text_byte;
				seen_count++;
				len = active_len();
				if (len != 0 && seen_count >= len) begin
					hit = 1'b1;
					for (int unsigned k = 0; k < len; k++)
						if (window_q[len-1-k] != needle_byte(k))
							hit = 1'b0;
					if (hit) begin
						pos = 17'(seen_count - len);
						if (!any_hit)
							earliest_hit = pos[sfls_pkg::POS_W-1:0];
						latest_hit = pos[sfls_pkg::POS_W-1:0];
						any_hit = 1'b1;
					end
				end
			end
		end
		if (it.end_of_text) begin
			res.too_long = text_overflow;
			if (active_len() == 0) begin
				res.found     = 1'b1;
				res.first_pos = '0;
				res.last_pos  = seen_count[sfls_pkg::POS_W-1:0];
			end else if (any_hit) begin
				res.found     = 1'b1;
				res.first_pos = earliest_hit;
				res.last_pos  = latest_hit;
			end else begin
				res.found     = 1'b0;
				res.first_pos = '0;
				res.last_pos  = '0;
			end
			expected_q.push_back(res);
			clear_search();
		end
	endtask

	// text driver
	text_item_t cur_item;
	int         send_gap = 0;

	always @(posedge clk) begin : text_driver
		logic take;
		if (arst_n) begin
			take = s_tvalid && s_tready;
			if (take) begin
				search_predict(cur_item);
				accepted_items++;
				if (idle_on && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 14);
			end
			if (!s_tvalid || take) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pend_items.size() > 0) begin
					cur_item = pend_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.text_byte;
					s_tuser  <= cur_item.has_byte;
					s_tlast  <= cur_item.end_of_text;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	int stall_left = 0;

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		search_result_t want;
		search_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[sfls_pkg::OUT_FIELD_W-1:0];
				result_count++;
				if (expected_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("found", want.found, got.found);
					check_field("first_position", want.first_pos, got.first_pos);
					check_field("last_position", want.last_pos, got.last_pos);
					check_field("too_long", want.too_long, got.too_long);
				end
				check_field("tdata padding", 0,
					m_tdata[sfls_pkg::OUT_TDATA_W-1:sfls_pkg::OUT_FIELD_W]);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// register write, only issued while nothing is in flight
	task automatic reg_write(input logic [sfls_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_index <= sfls_pkg::CFG_IDX_W'($urandom_range(0, 3));
		cfg_data  <= {$urandom, $urandom};
		case (idx)
			sfls_pkg::REG_NEEDLE_LO:  needle_lo = value;
			sfls_pkg::REG_NEEDLE_HI:  needle_hi = value;
			sfls_pkg::REG_NEEDLE_LEN: needle_len = value[sfls_pkg::LEN_W-1:0];
			default: ;
		endcase
		config_count++;
	endtask

	// sender holds off until every item and result has passed
	task automatic wait_idle();
		while (accepted_items != pushed_items || expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_FLUSH) @(posedge clk);
	endtask

	task automatic push_item(input sfls_pkg::byte_t b, input bit has, input bit eot);
		text_item_t it;
		it.text_byte   = b;
		it.has_byte    = has;
		it.end_of_text = eot;
		pend_items.push_back(it);
		pushed_items++;
	endtask

	// turn text_buf into items, with occasional ignored items in between when noisy is set
	task automatic send_text(input int unsigned close_mode, input bit noisy);
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(text_buf[i], 1'b1, close_mode == CLOSE_ON_BYTE && i == n - 1);
		end
		if (close_mode == CLOSE_BARE || (close_mode == CLOSE_ON_BYTE && n == 0))
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		text_buf.delete();
	endtask

	// random needle, then a batch of texts seeded with copies of it
	task automatic random_phase();
		int unsigned     nlen;
		int unsigned     eff;
		int unsigned     span;
		int unsigned     base;
		int unsigned     tlen;
		int unsigned     pos;
		int unsigned     close_mode;
		int              ntext;
		int              start_count;
		logic [63:0]     lo;
		logic [63:0]     hi;
		logic [63:0]     lenw;
		sfls_pkg::byte_t pat [16];
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4:  nlen = $urandom_range(0, 2);
			15, 16:         nlen = $urandom_range(9, 16);
			17, 18, 19:     nlen = $urandom_range(17, 31);
			default:        nlen = $urandom_range(3, 8);
		endcase
		eff  = (nlen > sfls_pkg::NEEDLE_LIM) ? sfls_pkg::NEEDLE_LIM : nlen;
		span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
		base = (span == 256) ? 0 : $urandom_range(0, 252);
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		for (int k = 0; k < 16; k++) begin
			if (k < eff) begin
				pat[k] = 8'(base + $urandom_range(0, span - 1));
				if (k < 8)
					lo[8*k +: 8] = pat[k];
				else
					hi[8*(k-8) +: 8] = pat[k];
			end
		end
		lenw = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
		lenw[sfls_pkg::LEN_W-1:0] = sfls_pkg::LEN_W'(nlen);
		reg_write(sfls_pkg::REG_NEEDLE_LO, lo);
		reg_write(sfls_pkg::REG_NEEDLE_HI, hi);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, lenw);
		ntext = $urandom_range(3, 8);
		start_count = pushed_items;
		for (int t = 0; t < ntext; t++) begin
			tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 40);
			for (int i = 0; i < tlen; i++)
				text_buf.push_back(8'(base + $urandom_range(0, span - 1)));
			repeat ($urandom_range(0, 3)) begin
				if (eff > 0 && eff <= tlen) begin
					pos = $urandom_range(0, tlen - eff);
					for (int k = 0; k < eff; k++)
						text_buf[pos + k] = pat[k];
				end
			end
			case ($urandom_range(0, 19))
				0, 1:    close_mode = CLOSE_NONE;
				default: close_mode = ($urandom_range(0, 1) == 0) ? CLOSE_ON_BYTE : CLOSE_BARE;
			endcase
			send_text(close_mode, 1'b1);
		end
		// ignored items are not counted
		foreach (pend_items[i])
			if (!pend_items[i].has_byte && !pend_items[i].end_of_text)
				start_count++;
		random_items += pushed_items - start_count;
		wait_idle();
	endtask

	// stimulus sequence
	initial begin : stimulus
		sfls_pkg::byte_t fill;
		for (int i = 0; i < sfls_pkg::NEEDLE_LIM; i++)
			window_q[i] = 8'h00;
		while (!arst_n)
			@(posedge clk);

		// needle "ab", unused index written with garbage
		reg_write(sfls_pkg::REG_NEEDLE_LO, 64'h0000_0000_0000_6261);
		reg_write(sfls_pkg::REG_NEEDLE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'd2);
		reg_write(REG_SPARE, 64'hA5A5_5A5A_0F0F_F0F0);
		// two separate matches, close on the last byte
		text_buf = '{8'h78, 8'h61, 8'h62, 8'h61, 8'h62};
		send_text(CLOSE_ON_BYTE, 1'b0);
		// ignored item inside the text, bare end marker
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		// needle longer than the text
		text_buf = '{8'h61};
		send_text(CLOSE_ON_BYTE, 1'b0);
		wait_idle();

		// empty needle, upper bits of the length register set
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
		text_buf = '{8'h00, 8'hFF, 8'h10};
		send_text(CLOSE_BARE, 1'b0);
		push_item(8'h55, 1'b0, 1'b1);
		wait_idle();

		// length above the limit saturates to 16, extreme byte values
		reg_write(sfls_pkg::REG_NEEDLE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(sfls_pkg::REG_NEEDLE_HI, 64'h0000_0000_0000_0000);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'd31);
		for (int i = 0; i < 16; i++)
			text_buf.push_back((i < 8) ? 8'hFF : 8'h00);
		send_text(CLOSE_ON_BYTE, 1'b0);
		wait_idle();

		// needle rewritten in the middle of a text, earlier match kept
		reg_write(sfls_pkg::REG_NEEDLE_LO, 64'h0000_0000_0000_6261);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'd2);
		text_buf = '{8'h61, 8'h62};
		send_text(CLOSE_NONE, 1'b0);
		wait_idle();
		reg_write(sfls_pkg::REG_NEEDLE_LO, 64'h0000_0000_0000_0063);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'd1);
		text_buf = '{8'h63};
		send_text(CLOSE_BARE, 1'b0);
		wait_idle();

		// text past the length limit, match before and after the cut
		reg_write(sfls_pkg::REG_NEEDLE_LO, 64'h0000_0000_007A_7978);
		reg_write(sfls_pkg::REG_NEEDLE_LEN, 64'd3);
		for (int i = 0; i < sfls_pkg::MAX_TEXT + 10; i++) begin
			fill = 8'($urandom_range(0, 3));
			if (i >= 10 && i < 13)
				fill = 8'(8'h78 + (i - 10));
			if (i >= sfls_pkg::MAX_TEXT - 3 && i < sfls_pkg::MAX_TEXT)
				fill = 8'(8'h78 + (i - (sfls_pkg::MAX_TEXT - 3)));
			if (i >= sfls_pkg::MAX_TEXT + 2 && i < sfls_pkg::MAX_TEXT + 5)
				fill = 8'(8'h78 + (i - (sfls_pkg::MAX_TEXT + 2)));
			text_buf.push_back(fill);
		end
		send_text(CLOSE_ON_BYTE, 1'b0);
		wait_idle();

		// random needles and texts, no idling near the end
		while (random_items < 1750) begin
			if (random_items >= 1450)
				idle_on = 1'b0;
			random_phase();
		end

		for (int i = 0; i < 5000 && expected_q.size() != 0; i++)
			@(posedge clk);
		repeat (PIPE_FLUSH * 4) @(posedge clk);
		if (expected_q.size() != 0) begin
			error_count += expected_q.size();
			$display("%0t: %0d results never arrived", $time, expected_q.size());
		end
		$display("%0d items accepted, %0d results checked over %0d register writes,",
			accepted_items, result_count, config_count);
		$display("covering empty, saturated and rewritten needles and an oversized text");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("%0t: timeout", $time);
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/sfls_pkg.sv
hdl/sfls_cfg_regs.sv
hdl/sfls_match.sv
hdl/substring_first_last_search.sv
test/tb.sv
